### design/rtc3w_pkg.sv
// ---------------------------------------------------------------------------
// rtc3w_pkg
// Shared types and constants for the three-wire RTC serial master: opcodes,
// sequencer phases and command byte encodings.
// ---------------------------------------------------------------------------
package rtc3w_pkg;

    localparam int BURST_BYTES_DEF = 7;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_SWR   = 3'd1,
        OP_SRD   = 3'd2,
        OP_BWR   = 3'd3,
        OP_BRD   = 3'd4,
        OP_LOAD  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    localparam logic [7:0] CMD_SINGLE   = 8'h80;
    localparam logic [7:0] CMD_READ_BIT = 8'h01;
    localparam logic [7:0] CMD_BURST_WR = 8'hBE;
    localparam logic [7:0] CMD_BURST_RD = 8'hBF;

    // Command byte for a transaction start; only opcodes 1..4 reach this.
    function automatic logic [7:0] command_byte(input logic [2:0] op, input logic [4:0] addr);
        logic [7:0] base;
        begin
            base = {2'b00, addr, 1'b0} | CMD_SINGLE;
            unique case (op)
                OP_SWR:  command_byte = base;
                OP_SRD:  command_byte = base | CMD_READ_BIT;
                OP_BWR:  command_byte = CMD_BURST_WR;
                OP_BRD:  command_byte = CMD_BURST_RD;
                default: command_byte = 8'h00;
            endcase
        end
    endfunction

endpackage

### design/three_wire_rtc_serial_master.sv
// An accepted tick has its result in the output register in the following cycle.
// Throughput: one tick per clock cycle; the next tick is accepted while the
// previous result waits, as long as the output register is free or being taken.
// A transaction spans 16 * (1 + data bytes) + 1 ticks (single: 1 byte, burst:
// BURST_BYTES). Reset puts the sequencer idle with IO released high; the burst
// buffer is not cleared and must be loaded before a burst write.
// ---------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Tick-driven master for a CE / SCLK / IO serial link, LSB first, with single
// and burst read and write transactions.
// ---------------------------------------------------------------------------
module three_wire_rtc_serial_master #(
    parameter int BURST_BYTES = rtc3w_pkg::BURST_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] op,
    input  logic [4:0] reg_addr,
    input  logic [7:0] wr_byte,
    input  logic [2:0] byte_index,
    input  logic       io_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ce,
    output logic       sclk,
    output logic       io_out,
    output logic       io_drive,
    output logic       busy_res,
    output logic       read_valid,
    output logic [7:0] read_byte,
    output logic [2:0] read_index,
    output logic       done_res
);
    import rtc3w_pkg::*;

    localparam int         IDX_W     = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
    localparam logic [3:0] BURST_CNT = 4'(BURST_BYTES);

    // sequencer state
    phase_t     phase_reg, phase_next;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] bit_count_reg, bit_count_next;
    logic [3:0] byte_count_reg, byte_count_next;
    logic       clock_half_reg, clock_half_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] single_data_reg, single_data_next;
    logic       io_level_reg, io_level_next;

    logic [7:0] burst_buf_reg [BURST_BYTES];
    logic       buf_wr;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic       ce_reg, ce_next;
    logic       sclk_reg, sclk_next;
    logic       io_out_reg, io_out_next;
    logic       io_drive_reg, io_drive_next;
    logic       busy_reg, busy_next;
    logic       read_valid_reg, read_valid_next;
    logic [7:0] read_byte_reg, read_byte_next;
    logic [2:0] read_index_reg, read_index_next;
    logic       done_reg, done_next;

    // effective state for this tick (a start tick runs command bit 0 at once)
    logic       in_accept;
    logic       start;
    phase_t     ph_e;
    logic [7:0] shift_e;
    logic [2:0] bit_e;
    logic [3:0] byte_e;
    logic       half_e;
    logic [2:0] kind_e;
    logic       reading;
    logic [7:0] sampled;
    logic [3:0] byte_inc;
    logic [3:0] total;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign start = (phase_reg == PH_IDLE) && (op == OP_SWR || op == OP_SRD ||
                                              op == OP_BWR || op == OP_BRD);

    always_comb
    begin
        ph_e    = start ? PH_CMD : phase_reg;
        shift_e = start ? command_byte(op, reg_addr) : shift_reg;
        bit_e   = start ? 3'd0 : bit_count_reg;
        byte_e  = start ? 4'd0 : byte_count_reg;
        half_e  = start ? 1'b0 : clock_half_reg;
        kind_e  = start ? op : kind_reg;
        reading = (ph_e == PH_DATA) && (kind_e == OP_SRD || kind_e == OP_BRD);
        sampled = shift_e | ((io_in ? 8'd1 : 8'd0) << bit_e);
        byte_inc = byte_e + 4'd1;
        total    = (kind_e == OP_SWR || kind_e == OP_SRD) ? 4'd1 : BURST_CNT;

        phase_next       = phase_reg;
        shift_next       = shift_reg;
        bit_count_next   = bit_count_reg;
        byte_count_next  = byte_count_reg;
        clock_half_next  = clock_half_reg;
        kind_next        = kind_reg;
        single_data_next = single_data_reg;
        io_level_next    = io_level_reg;
        buf_wr           = 1'b0;

        ce_next         = 1'b0;
        sclk_next       = 1'b0;
        io_out_next     = 1'b0;
        io_drive_next   = 1'b0;
        busy_next       = 1'b0;
        read_valid_next = 1'b0;
        read_byte_next  = 8'h00;
        read_index_next = 3'd0;
        done_next       = 1'b0;

        if (start)
        begin
            kind_next        = op;
            single_data_next = wr_byte;
        end

        unique case (ph_e)
            PH_IDLE:
            begin
                buf_wr        = (op == OP_LOAD) && ({1'b0, byte_index} < BURST_CNT);
                io_out_next   = io_level_reg;
                io_drive_next = ~io_level_reg;
            end
            PH_DONE:
            begin
                busy_next     = 1'b1;
                io_out_next   = io_level_reg;
                io_drive_next = ~io_level_reg;
                done_next     = 1'b1;
                phase_next    = PH_IDLE;
            end
            default:
            begin
                busy_next       = 1'b1;
                ce_next         = 1'b1;
                sclk_next       = half_e;
                phase_next      = ph_e;
                shift_next      = shift_e;
                bit_count_next  = bit_e;
                byte_count_next = byte_e;
                if (reading)
                begin
                    // sample on the low tick, ahead of the pulse
                    if (!half_e)
                    begin
                        shift_next = sampled;
                        if (bit_e == 3'd7)
                        begin
                            read_valid_next = 1'b1;
                            read_byte_next  = sampled;
                            read_index_next = byte_e[2:0];
                        end
                    end
                end
                else
                begin
                    io_drive_next = 1'b1;
                    io_out_next   = shift_e[bit_e];
                end

                if (!half_e)
                begin
                    clock_half_next = 1'b1;
                end
                else
                begin
                    clock_half_next = 1'b0;
                    bit_count_next  = bit_e + 3'd1;
                    if (bit_e == 3'd7)
                    begin
                        if (ph_e == PH_CMD)
                        begin
                            phase_next      = PH_DATA;
                            byte_count_next = 4'd0;
                            if (kind_e == OP_SWR)
                                shift_next = single_data_reg;
                            else if (kind_e == OP_BWR)
                                shift_next = burst_buf_reg[0];
                            else
                                shift_next = 8'h00;
                        end
                        else
                        begin
                            byte_count_next = byte_inc;
                            if (byte_inc >= total)
                            begin
                                phase_next    = PH_DONE;
                                io_level_next = ~reading;
                            end
                            else if (reading)
                                shift_next = 8'h00;
                            else
                                shift_next = burst_buf_reg[byte_inc[IDX_W-1:0]];
                        end
                    end
                end
            end
        endcase

        out_valid_next = in_accept | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 3'd0;
            byte_count_reg <= 4'd0;
            clock_half_reg <= 1'b0;
            kind_reg       <= 3'd0;
            io_level_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                byte_count_reg <= byte_count_next;
                clock_half_reg <= clock_half_next;
                kind_reg       <= kind_next;
                io_level_reg   <= io_level_next;
            end
        end
    end

    // payload: shift data, single byte and the result fields
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            shift_reg       <= shift_next;
            single_data_reg <= single_data_next;
            ce_reg          <= ce_next;
            sclk_reg        <= sclk_next;
            io_out_reg      <= io_out_next;
            io_drive_reg    <= io_drive_next;
            busy_reg        <= busy_next;
            read_valid_reg  <= read_valid_next;
            read_byte_reg   <= read_byte_next;
            read_index_reg  <= read_index_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && buf_wr)
            burst_buf_reg[byte_index[IDX_W-1:0]] <= wr_byte;
    end

    assign out_valid  = out_valid_reg;
    assign ce         = ce_reg;
    assign sclk       = sclk_reg;
    assign io_out     = io_out_reg;
    assign io_drive   = io_drive_reg;
    assign busy_res   = busy_reg;
    assign read_valid = read_valid_reg;
    assign read_byte  = read_byte_reg;
    assign read_index = read_index_reg;
    assign done_res   = done_reg;

    a_read_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && read_valid_reg |-> ce_reg && !sclk_reg && !io_drive_reg)
        else $error("received byte reported outside a sampling tick");

    a_done_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> busy_reg && !ce_reg && !sclk_reg)
        else $error("final tick with CE or SCLK high");

    a_ce_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ce_reg |-> busy_reg)
        else $error("CE high outside a transaction");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && phase_reg == PH_DONE |=> phase_reg == PH_IDLE && out_valid_reg && done_reg)
        else $error("final tick did not return the sequencer to idle");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with an empty result register");

endmodule
